// ----- design/ctl_pkg.sv -----
package ctl_pkg;

	localparam int MAX_BATCH = 64;
	localparam int MAX_DIM   = 128;

	// field widths
	localparam int FEAW = 16;
	localparam int LBLW = 16;

	// derived widths
	localparam int SCW    = $clog2(MAX_BATCH + 1);
	localparam int SIW    = $clog2(MAX_BATCH);
	localparam int EIW    = $clog2(MAX_DIM + 2);
	localparam int VLW    = $clog2(MAX_DIM + 1);
	localparam int FDEPTH = MAX_BATCH * MAX_DIM;
	localparam int FAW    = $clog2(FDEPTH);
	localparam int NRMW   = 31 + $clog2(MAX_DIM);
	localparam int RTW    = (NRMW + 1) / 2;
	localparam int DENW   = 2 * RTW;
	localparam int DOTW   = NRMW + 1;
	localparam int DVDW   = DOTW + 12;
	localparam int INFW   = LBLW + VLW + NRMW;
	localparam int COSW   = 14;
	localparam int TW     = 19;
	localparam int SUMW   = 17 + $clog2(MAX_BATCH);
	localparam int SQCW   = $clog2(RTW + 1);
	localparam int DVCW   = $clog2(DVDW + 1);

	localparam logic [15:0] MARGIN_RST = 16'd4096;
	localparam int          COS_ONE    = 4096;
	localparam int          MEAN_MAX   = 131071;

	typedef struct packed {
		logic signed [FEAW-1:0] feature_value;
		logic [LBLW-1:0]        sample_label;
		logic                   last_of_sample;
		logic                   last_of_batch;
	} feature_t;

	typedef struct packed {
		logic [16:0] mean_loss;
		logic [6:0]  triplet_count;
		logic        overflow_flag;
	} result_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_ANCHOR,
		ST_SRCH_RD,
		ST_SRCH_CHK,
		ST_NRM_RD,
		ST_SQA_GO,
		ST_SQ_A,
		ST_SQ_B,
		ST_DOT,
		ST_DIV_GO,
		ST_DIV,
		ST_COS,
		ST_MEAN,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		B_HOLD,
		B_CLR,
		B_INC,
		B_POS,
		B_NEG
	} b_op_t;

	typedef struct packed {
		logic  load;
		logic  emit;
		logic  acc_clr;
		logic  a_clr;
		logic  a_inc;
		b_op_t b_op;
		logic  srch_clr;
		logic  srch_upd;
		logic  role_clr;
		logic  role_set_neg;
		logic  sq_start_a;
		logic  sq_start_b;
		logic  dot_clr;
		logic  dot_run;
		logic  div_start_cos;
		logic  div_start_mean;
		logic  cos_zero;
		logic  cos_take;
		logic  term_acc;
	} cmd_t;

	typedef struct packed {
		logic a_done;
		logic b_done;
		logic both_nx;
		logic k_done;
		logic norm_zero;
		logic sq_busy;
		logic div_busy;
		logic count_zero;
		logic role_neg;
		logic out_free;
	} status_t;

endpackage

// ----- design/cosine_triplet_loss.sv -----
// Loading: one feature element per cycle, no stall while the block is loading.
// Compute after the batch end, per anchor: a partner search over the stored samples, then
// per cosine two square roots, the dot product over the vector length and a divide.
// Mean: a divide; result waits in an output register.
// arst_n clears control state and sets margin to 1.0; sample stores are not cleared.
module cosine_triplet_loss (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              feature_valid,
	output logic              feature_stall,
	input  ctl_pkg::feature_t feature,
	output logic              result_valid,
	input  logic              result_stall,
	output ctl_pkg::result_t  result,
	input  logic              margin_valid,
	output logic              margin_ready,
	input  logic [15:0]       margin
);

	ctl_pkg::cmd_t    cmd;
	ctl_pkg::status_t status;

	// register writes must arrive only while idle; the block itself does not enforce this
	assign margin_ready = 1'b1;

	ctl_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.feature_valid (feature_valid),
		.batch_end     (feature.last_of_batch),
		.feature_stall (feature_stall),
		.status        (status),
		.cmd           (cmd)
	);

	ctl_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.feature      (feature),
		.margin_we    (margin_valid && margin_ready),
		.margin_wdata (margin),
		.cmd          (cmd),
		.status       (status),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result)
	);

`ifndef SYNTHESIS
	a_stall_after_batch: assert property (@(posedge clk) disable iff (!arst_n)
		feature_valid && !feature_stall && feature.last_of_batch |=> feature_stall)
		else $error("input not stalled after batch end");
	a_zero_mean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.triplet_count == 7'd0 |-> result.mean_loss == 17'd0)
		else $error("nonzero mean without triplets");
	a_result_after_compute: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(feature_stall))
		else $error("result raised while loading");
`endif

endmodule

// ----- design/ctl_ram.sv -----
module ctl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

// ----- design/ctl_ctrl.sv -----
module ctl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              feature_valid,
	input  logic              batch_end,
	output logic              feature_stall,
	input  ctl_pkg::status_t  status,
	output ctl_pkg::cmd_t     cmd
);

	ctl_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ctl_pkg::ST_LOAD;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ctl_pkg::ST_LOAD: begin
				if (feature_valid && batch_end) state_nx = ctl_pkg::ST_ANCHOR;
			end
			ctl_pkg::ST_ANCHOR: begin
				priority if (!status.a_done)   state_nx = ctl_pkg::ST_SRCH_RD;
				else if (status.count_zero)    state_nx = ctl_pkg::ST_EMIT;
				else                           state_nx = ctl_pkg::ST_MEAN;
			end
			ctl_pkg::ST_SRCH_RD: state_nx = ctl_pkg::ST_SRCH_CHK;
			ctl_pkg::ST_SRCH_CHK: begin
				priority if (status.b_done)  state_nx = ctl_pkg::ST_ANCHOR;
				else if (status.both_nx)     state_nx = ctl_pkg::ST_NRM_RD;
				else                         state_nx = ctl_pkg::ST_SRCH_RD;
			end
			ctl_pkg::ST_NRM_RD: state_nx = ctl_pkg::ST_SQA_GO;
			ctl_pkg::ST_SQA_GO: state_nx = ctl_pkg::ST_SQ_A;
			ctl_pkg::ST_SQ_A: begin
				if (!status.sq_busy) state_nx = ctl_pkg::ST_SQ_B;
			end
			ctl_pkg::ST_SQ_B: begin
				priority if (status.sq_busy) state_nx = ctl_pkg::ST_SQ_B;
				else if (status.norm_zero)   state_nx = ctl_pkg::ST_COS;
				else                         state_nx = ctl_pkg::ST_DOT;
			end
			ctl_pkg::ST_DOT: begin
				if (status.k_done) state_nx = ctl_pkg::ST_DIV_GO;
			end
			ctl_pkg::ST_DIV_GO: state_nx = ctl_pkg::ST_DIV;
			ctl_pkg::ST_DIV: begin
				if (!status.div_busy) state_nx = ctl_pkg::ST_COS;
			end
			ctl_pkg::ST_COS: begin
				if (status.role_neg) state_nx = ctl_pkg::ST_ANCHOR;
				else                 state_nx = ctl_pkg::ST_NRM_RD;
			end
			ctl_pkg::ST_MEAN: begin
				if (!status.div_busy) state_nx = ctl_pkg::ST_EMIT;
			end
			ctl_pkg::ST_EMIT: begin
				if (status.out_free) state_nx = ctl_pkg::ST_LOAD;
			end
			default: state_nx = ctl_pkg::ST_LOAD;
		endcase
	end

	// commands
	always_comb begin
		cmd           = '0;
		cmd.b_op      = ctl_pkg::B_HOLD;
		feature_stall = 1'b1;
		unique case (state_q)
			ctl_pkg::ST_LOAD: begin
				feature_stall = 1'b0;
				cmd.load      = feature_valid;
				if (feature_valid && batch_end) begin
					cmd.a_clr   = 1'b1;
					cmd.acc_clr = 1'b1;
				end
			end
			ctl_pkg::ST_ANCHOR: begin
				priority if (!status.a_done) begin
					cmd.b_op     = ctl_pkg::B_CLR;
					cmd.srch_clr = 1'b1;
					cmd.role_clr = 1'b1;
				end else if (!status.count_zero) begin
					cmd.div_start_mean = 1'b1;
				end else begin
					cmd.b_op = ctl_pkg::B_HOLD;
				end
			end
			ctl_pkg::ST_SRCH_CHK: begin
				priority if (status.b_done) begin
					cmd.a_inc = 1'b1;
				end else if (status.both_nx) begin
					cmd.srch_upd = 1'b1;
					cmd.b_op     = ctl_pkg::B_POS;
				end else begin
					cmd.srch_upd = 1'b1;
					cmd.b_op     = ctl_pkg::B_INC;
				end
			end
			ctl_pkg::ST_SQA_GO: cmd.sq_start_a = 1'b1;
			ctl_pkg::ST_SQ_A: begin
				if (!status.sq_busy) cmd.sq_start_b = 1'b1;
			end
			ctl_pkg::ST_SQ_B: begin
				if (!status.sq_busy) begin
					if (status.norm_zero) cmd.cos_zero = 1'b1;
					else                  cmd.dot_clr  = 1'b1;
				end
			end
			ctl_pkg::ST_DOT:    cmd.dot_run       = 1'b1;
			ctl_pkg::ST_DIV_GO: cmd.div_start_cos = 1'b1;
			ctl_pkg::ST_DIV: begin
				if (!status.div_busy) cmd.cos_take = 1'b1;
			end
			ctl_pkg::ST_COS: begin
				if (status.role_neg) begin
					cmd.term_acc = 1'b1;
					cmd.a_inc    = 1'b1;
				end else begin
					cmd.role_set_neg = 1'b1;
					cmd.b_op         = ctl_pkg::B_NEG;
				end
			end
			ctl_pkg::ST_EMIT: begin
				if (status.out_free) cmd.emit = 1'b1;
			end
			default: cmd.b_op = ctl_pkg::B_HOLD;
		endcase
	end

endmodule

// ----- design/ctl_datapath.sv -----
module ctl_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_pkg::feature_t feature,
	input  logic              margin_we,
	input  logic [15:0]       margin_wdata,
	input  ctl_pkg::cmd_t     cmd,
	output ctl_pkg::status_t  status,
	input  logic              result_stall,
	output logic              result_valid,
	output ctl_pkg::result_t  result
);

	// load state
	logic [ctl_pkg::SCW-1:0]  sc_q;
	logic [ctl_pkg::EIW-1:0]  ei_q;
	logic [ctl_pkg::VLW-1:0]  vl_q;
	logic                     drop_q;
	logic [ctl_pkg::NRMW-1:0] nacc_q;
	logic [15:0]              margin_q;

	// compute state
	logic [ctl_pkg::SCW-1:0]         a_q, b_q, pos_q, neg_q;
	logic                            pos_f_q, neg_f_q, role_neg_q;
	logic [ctl_pkg::SCW-1:0]         cnt_q;
	logic [ctl_pkg::SUMW-1:0]        sum_q;
	logic [ctl_pkg::VLW-1:0]         k_q, k_s1;
	logic                            v_s1;
	logic signed [ctl_pkg::DOTW-1:0] dot_q;
	logic signed [ctl_pkg::COSW-1:0] cp_q, cn_q;
	logic [ctl_pkg::RTW-1:0]         ra_q, rb_q;

	// sqrt unit
	logic                        sq_busy_q, sq_tgt_b_q;
	logic [ctl_pkg::SQCW-1:0]    sq_cnt_q;
	logic [2*ctl_pkg::RTW-1:0]   sq_val_q;
	logic [ctl_pkg::RTW+1:0]     sq_rem_q;
	logic [ctl_pkg::RTW-1:0]     sq_root_q;

	// divider unit
	logic                        dv_busy_q;
	logic [ctl_pkg::DVCW-1:0]    dv_cnt_q;
	logic [ctl_pkg::DVDW-1:0]    dv_num_q, dv_quo_q;
	logic [ctl_pkg::DENW-1:0]    dv_den_q, dv_rem_q;

	logic result_valid_q;
	ctl_pkg::result_t result_q;

	// memories
	logic [ctl_pkg::FAW-1:0]  f_waddr, f_raddr0, f_raddr1;
	logic [ctl_pkg::FEAW-1:0] f_rd0, f_rd1;
	logic                     f_we, i_we;
	logic [ctl_pkg::INFW-1:0] i_wdata, i_rd0, i_rd1;

	// ---------------- load path ----------------
	logic [ctl_pkg::VLW-1:0]  limit, vl_first, vl_new, wlen;
	logic [ctl_pkg::EIW-1:0]  ei_inc;
	logic                     take, wr, end_s;
	logic [31:0]              v_sq;
	logic [ctl_pkg::NRMW-1:0] nbase, nacc_nx;

	assign end_s  = feature.last_of_sample | feature.last_of_batch;
	assign limit  = (vl_q != '0) ? vl_q : ctl_pkg::VLW'(ctl_pkg::MAX_DIM);
	assign take   = sc_q < ctl_pkg::SCW'(ctl_pkg::MAX_BATCH);
	assign wr     = take && (ei_q < ctl_pkg::EIW'(limit));
	assign ei_inc = (ei_q <= ctl_pkg::EIW'(ctl_pkg::MAX_DIM)) ? ei_q + 1'b1 : ei_q;
	assign vl_first = (ei_inc < ctl_pkg::EIW'(ctl_pkg::MAX_DIM)) ?
		ctl_pkg::VLW'(ei_inc) : ctl_pkg::VLW'(ctl_pkg::MAX_DIM);
	assign vl_new = (vl_q != '0) ? vl_q : vl_first;
	assign wlen   = (ei_inc < ctl_pkg::EIW'(vl_new)) ? ctl_pkg::VLW'(ei_inc) : vl_new;
	// square of the element, formed at full 32-bit width
	assign v_sq   = $unsigned(32'(feature.feature_value) * 32'(feature.feature_value));
	assign nbase  = (ei_q == '0) ? '0 : nacc_q;
	assign nacc_nx = wr ? nbase + ctl_pkg::NRMW'(v_sq) : nbase;

	assign f_we    = cmd.load && wr;
	assign f_waddr = ctl_pkg::FAW'(32'(sc_q[ctl_pkg::SIW-1:0]) * ctl_pkg::MAX_DIM + 32'(ei_q));
	assign i_we    = cmd.load && take && end_s;
	assign i_wdata = {feature.sample_label, wlen, nacc_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q     <= '0;
			ei_q     <= '0;
			vl_q     <= '0;
			drop_q   <= 1'b0;
			margin_q <= ctl_pkg::MARGIN_RST;
		end else begin
			if (margin_we) margin_q <= margin_wdata;
			if (cmd.load) begin
				if (!wr) drop_q <= 1'b1;
				if (end_s) begin
					ei_q <= '0;
					if (take) begin
						sc_q <= sc_q + 1'b1;
						vl_q <= vl_new;
					end
				end else begin
					ei_q <= ei_inc;
				end
			end else if (cmd.emit) begin
				sc_q   <= '0;
				ei_q   <= '0;
				vl_q   <= '0;
				drop_q <= 1'b0;
			end
		end
	end

	// running sum of squares of the sample being loaded
	always_ff @(posedge clk) begin
		if (cmd.load && take) nacc_q <= nacc_nx;
	end

	ctl_ram #(.WIDTH(ctl_pkg::FEAW), .DEPTH(ctl_pkg::FDEPTH)) u_feat (
		.clk    (clk),
		.we     (f_we),
		.waddr  (f_waddr),
		.wdata  (feature.feature_value),
		.raddr0 (f_raddr0),
		.raddr1 (f_raddr1),
		.rdata0 (f_rd0),
		.rdata1 (f_rd1)
	);

	ctl_ram #(.WIDTH(ctl_pkg::INFW), .DEPTH(ctl_pkg::MAX_BATCH)) u_info (
		.clk    (clk),
		.we     (i_we),
		.waddr  (sc_q[ctl_pkg::SIW-1:0]),
		.wdata  (i_wdata),
		.raddr0 (a_q[ctl_pkg::SIW-1:0]),
		.raddr1 (b_q[ctl_pkg::SIW-1:0]),
		.rdata0 (i_rd0),
		.rdata1 (i_rd1)
	);

	assign f_raddr0 = ctl_pkg::FAW'(32'(a_q[ctl_pkg::SIW-1:0]) * ctl_pkg::MAX_DIM + 32'(k_q));
	assign f_raddr1 = ctl_pkg::FAW'(32'(b_q[ctl_pkg::SIW-1:0]) * ctl_pkg::MAX_DIM + 32'(k_q));

	// sample info fields
	logic [ctl_pkg::LBLW-1:0] lbl_a, lbl_b;
	logic [ctl_pkg::VLW-1:0]  wl_a, wl_b;
	logic [ctl_pkg::NRMW-1:0] nrm_a, nrm_b;

	assign lbl_a = i_rd0[ctl_pkg::INFW-1 -: ctl_pkg::LBLW];
	assign lbl_b = i_rd1[ctl_pkg::INFW-1 -: ctl_pkg::LBLW];
	assign wl_a  = i_rd0[ctl_pkg::NRMW +: ctl_pkg::VLW];
	assign wl_b  = i_rd1[ctl_pkg::NRMW +: ctl_pkg::VLW];
	assign nrm_a = i_rd0[ctl_pkg::NRMW-1:0];
	assign nrm_b = i_rd1[ctl_pkg::NRMW-1:0];

	// ---------------- partner search ----------------
	logic pos_f_nx, neg_f_nx;
	logic [ctl_pkg::SCW-1:0] pos_nx, neg_nx;

	always_comb begin
		pos_f_nx = pos_f_q;
		neg_f_nx = neg_f_q;
		pos_nx   = pos_q;
		neg_nx   = neg_q;
		if (b_q != a_q) begin
			if (lbl_a == lbl_b) begin
				if (!pos_f_q) begin
					pos_f_nx = 1'b1;
					pos_nx   = b_q;
				end
			end else if (!neg_f_q) begin
				neg_f_nx = 1'b1;
				neg_nx   = b_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q        <= '0;
			b_q        <= '0;
			pos_f_q    <= 1'b0;
			neg_f_q    <= 1'b0;
			role_neg_q <= 1'b0;
		end else begin
			if (cmd.a_clr)      a_q <= '0;
			else if (cmd.a_inc) a_q <= a_q + 1'b1;
			unique case (cmd.b_op)
				ctl_pkg::B_HOLD: b_q <= b_q;
				ctl_pkg::B_CLR:  b_q <= '0;
				ctl_pkg::B_INC:  b_q <= b_q + 1'b1;
				ctl_pkg::B_POS:  b_q <= pos_nx;
				ctl_pkg::B_NEG:  b_q <= neg_q;
				default:         b_q <= b_q;
			endcase
			if (cmd.srch_clr) begin
				pos_f_q <= 1'b0;
				neg_f_q <= 1'b0;
			end else if (cmd.srch_upd) begin
				pos_f_q <= pos_f_nx;
				neg_f_q <= neg_f_nx;
			end
			if (cmd.role_clr)          role_neg_q <= 1'b0;
			else if (cmd.role_set_neg) role_neg_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.srch_upd) begin
			pos_q <= pos_nx;
			neg_q <= neg_nx;
		end
	end

	// ---------------- integer square root, two bits a step ----------------
	logic [ctl_pkg::RTW+2:0] sq_sh, sq_trial, sq_diff;
	logic                    sq_ge;
	logic [ctl_pkg::RTW-1:0] sq_root_nx;

	assign sq_sh      = {sq_rem_q[ctl_pkg::RTW:0], sq_val_q[2*ctl_pkg::RTW-1 -: 2]};
	assign sq_trial   = {1'b0, sq_root_q, 2'b01};
	assign sq_ge      = sq_sh >= sq_trial;
	assign sq_diff    = sq_sh - sq_trial;
	assign sq_root_nx = {sq_root_q[ctl_pkg::RTW-2:0], sq_ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
		end else if (cmd.sq_start_a || cmd.sq_start_b) begin
			sq_busy_q <= 1'b1;
		end else if (sq_busy_q && sq_cnt_q == ctl_pkg::SQCW'(1)) begin
			sq_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sq_start_a || cmd.sq_start_b) begin
			sq_cnt_q   <= ctl_pkg::SQCW'(ctl_pkg::RTW);
			sq_val_q   <= (2*ctl_pkg::RTW)'(cmd.sq_start_b ? nrm_b : nrm_a);
			sq_rem_q   <= '0;
			sq_root_q  <= '0;
			sq_tgt_b_q <= cmd.sq_start_b;
		end else if (sq_busy_q) begin
			sq_cnt_q  <= sq_cnt_q - 1'b1;
			sq_val_q  <= sq_val_q << 2;
			sq_rem_q  <= sq_ge ? sq_diff[ctl_pkg::RTW+1:0] : sq_sh[ctl_pkg::RTW+1:0];
			sq_root_q <= sq_root_nx;
			if (sq_cnt_q == ctl_pkg::SQCW'(1)) begin
				if (sq_tgt_b_q) rb_q <= sq_root_nx;
				else            ra_q <= sq_root_nx;
			end
		end
	end

	// ---------------- dot product ----------------
	logic signed [31:0] prod;
	logic               mask;

	assign prod = $signed(f_rd0) * $signed(f_rd1);
	assign mask = (k_s1 < wl_a) && (k_s1 < wl_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.dot_run && (k_q != vl_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dot_clr) begin
			k_q   <= '0;
			dot_q <= '0;
		end else begin
			if (cmd.dot_run && (k_q != vl_q)) k_q <= k_q + 1'b1;
			if (v_s1 && mask) dot_q <= dot_q + ctl_pkg::DOTW'(prod);
		end
		k_s1 <= k_q;
	end

	// ---------------- restoring divider, one bit a cycle ----------------
	logic                    dot_neg;
	logic [ctl_pkg::DOTW-1:0] dot_mag;
	logic [ctl_pkg::DENW-1:0] den_cos;
	logic [ctl_pkg::DENW:0]   dv_sh;
	logic                     dv_ge;
	logic [ctl_pkg::DENW:0]   dv_diff;

	assign dot_neg = dot_q < 0;
	assign dot_mag = dot_neg ? $unsigned(-dot_q) : $unsigned(dot_q);
	assign den_cos = ctl_pkg::DENW'(ra_q) * ctl_pkg::DENW'(rb_q);
	assign dv_sh   = {dv_rem_q, dv_num_q[ctl_pkg::DVDW-1]};
	assign dv_ge   = dv_sh >= {1'b0, dv_den_q};
	assign dv_diff = dv_sh - {1'b0, dv_den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_busy_q <= 1'b0;
		end else if (cmd.div_start_cos || cmd.div_start_mean) begin
			dv_busy_q <= 1'b1;
		end else if (dv_busy_q && dv_cnt_q == ctl_pkg::DVCW'(1)) begin
			dv_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start_cos) begin
			dv_num_q <= {dot_mag, 12'b0} + ctl_pkg::DVDW'(den_cos >> 1);
			dv_den_q <= den_cos;
		end else if (cmd.div_start_mean) begin
			dv_num_q <= ctl_pkg::DVDW'(sum_q) + ctl_pkg::DVDW'(cnt_q >> 1);
			dv_den_q <= ctl_pkg::DENW'(cnt_q);
		end else if (dv_busy_q) begin
			dv_num_q <= dv_num_q << 1;
		end
		if (cmd.div_start_cos || cmd.div_start_mean) begin
			dv_cnt_q <= ctl_pkg::DVCW'(ctl_pkg::DVDW);
			dv_rem_q <= '0;
			dv_quo_q <= '0;
		end else if (dv_busy_q) begin
			dv_cnt_q <= dv_cnt_q - 1'b1;
			dv_rem_q <= dv_ge ? dv_diff[ctl_pkg::DENW-1:0] : dv_sh[ctl_pkg::DENW-1:0];
			dv_quo_q <= {dv_quo_q[ctl_pkg::DVDW-2:0], dv_ge};
		end
	end

	// ---------------- similarity and loss accumulation ----------------
	logic [ctl_pkg::COSW-1:0]        q_clamp;
	logic signed [ctl_pkg::COSW-1:0] cos_val;
	logic signed [ctl_pkg::TW-1:0]   term;

	assign q_clamp = (dv_quo_q > ctl_pkg::DVDW'(ctl_pkg::COS_ONE)) ?
		ctl_pkg::COSW'(ctl_pkg::COS_ONE) : dv_quo_q[ctl_pkg::COSW-1:0];
	assign cos_val = dot_neg ? -$signed(q_clamp) : $signed(q_clamp);
	assign term    = $signed(ctl_pkg::TW'(margin_q)) - ctl_pkg::TW'(cp_q) + ctl_pkg::TW'(cn_q);

	always_ff @(posedge clk) begin
		if (cmd.cos_zero || cmd.cos_take) begin
			if (role_neg_q) cn_q <= cmd.cos_take ? cos_val : '0;
			else            cp_q <= cmd.cos_take ? cos_val : '0;
		end
		if (cmd.acc_clr) begin
			sum_q <= '0;
		end else if (cmd.term_acc && term > 0) begin
			sum_q <= sum_q + ctl_pkg::SUMW'($unsigned(term));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.acc_clr) begin
			cnt_q <= '0;
		end else if (cmd.term_acc) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// ---------------- result register ----------------
	logic [16:0] mean_val;

	assign mean_val = (cnt_q == '0) ? '0 :
		(dv_quo_q > ctl_pkg::DVDW'(ctl_pkg::MEAN_MAX)) ? 17'(ctl_pkg::MEAN_MAX) :
		dv_quo_q[16:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.mean_loss     <= mean_val;
			result_q.triplet_count <= 7'(cnt_q);
			result_q.overflow_flag <= drop_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// status to controller
	assign status.a_done     = a_q == sc_q;
	assign status.b_done     = b_q == sc_q;
	assign status.both_nx    = pos_f_nx && neg_f_nx;
	assign status.k_done     = k_q == vl_q;
	assign status.norm_zero  = (ra_q == '0) || (rb_q == '0);
	assign status.sq_busy    = sq_busy_q;
	assign status.div_busy   = dv_busy_q;
	assign status.count_zero = cnt_q == '0;
	assign status.role_neg   = role_neg_q;
	assign status.out_free   = !result_valid_q || !result_stall;

endmodule
